### sv/dtq_pkg.sv
// shared types and constants for the deadline timer queue
`default_nettype none

package dtq_pkg;

   localparam int TIME_W  = 48;
   localparam int DELAY_W = 32;
   localparam int SLACK_W = 32;
   localparam int TAG_W   = 16;
   localparam int MODE_W  = 2;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // request modes
   typedef enum logic [MODE_W-1:0] {
      MODE_SCHEDULE = 2'd0,
      MODE_CANCEL   = 2'd1,
      MODE_TICK     = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // what every cell of the chain does this cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_CANCEL = 2'd2,
      OP_POP    = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] deadline;
      logic [TAG_W-1:0]  tag;
      logic              canc;
   } entry_type;

   // command broadcast to all cells
   typedef struct packed {
      cell_op_type       op;
      logic [TIME_W-1:0] deadline;
      logic [TAG_W-1:0]  tag;
      logic              canc;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEADLINE,
      ST_INSERT,
      ST_CANCEL,
      ST_FIRE,
      ST_CALC,
      ST_STATUS
   } state_type;

endpackage

`default_nettype wire

### sv/dtq_cell.sv
// one queue slot: holds an entry and shifts it to or from its neighbors
`default_nettype none

module dtq_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dtq_pkg::cell_cmd_type cmd,
   input  wire dtq_pkg::entry_type   left_entry,
   input  wire logic                 left_gt,
   input  wire dtq_pkg::entry_type   right_entry,
   input  wire logic                 match_in,
   output dtq_pkg::entry_type        entry,
   output logic                      gt_out,
   output logic                      match_out
);

   dtq_pkg::entry_type entry_ff;
   dtq_pkg::entry_type entry_in;
   dtq_pkg::entry_type new_entry;
   logic               match;

   assign entry = entry_ff;

   // empty slots count as later than any deadline so an insert behind every valid entry lands in the first empty slot
   assign gt_out    = !entry_ff.valid || (entry_ff.deadline > cmd.deadline);
   assign match     = entry_ff.valid && entry_ff.canc && (entry_ff.tag == cmd.tag);
   assign match_out = match_in || match;

   always_comb begin
      new_entry.valid    = 1'b1;
      new_entry.deadline = cmd.deadline;
      new_entry.tag      = cmd.tag;
      new_entry.canc     = cmd.canc;
      entry_in           = entry_ff;
      case (cmd.op)
         dtq_pkg::OP_INSERT: begin
            if (gt_out) begin
               entry_in = left_gt ? left_entry : new_entry;
            end
         end
         dtq_pkg::OP_CANCEL: begin
            if (match_out) begin
               entry_in = right_entry;
            end
         end
         dtq_pkg::OP_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // only the valid bit is reset, the payload follows without reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.deadline <= entry_in.deadline;
      entry_ff.tag      <= entry_in.tag;
      entry_ff.canc     <= entry_in.canc;
   end

endmodule

`default_nettype wire

### sv/deadline_timer_queue.sv
// top level of the deadline timer queue: sequencer, output register and cell chain
`default_nettype none

// Deadline-ordered queue of callback tags held in a row of QUEUE_DEPTH slot cells,
// earliest deadline in slot 0, ties kept in arrival order. One request word is
// taken at a time. A schedule steps the sequencer through the saturating deadline
// add, the insert (all cells compare against the new deadline at once and shift
// right behind it), a pop for each due head, the registering of the re-arm sums
// and the status word. A tick skips the add and the insert, a cancel runs its
// cancel step and then the status word, and an unused mode gives only the status
// word; a stalled rsp channel holds the pops and the status word. Each request
// yields its fired words followed by one status word with last set. timer_slack
// is written through the csr port, which is always ready; write it only while the
// block is idle.
module deadline_timer_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // config write
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [dtq_pkg::SLACK_W-1:0]   csr_data,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [dtq_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [dtq_pkg::TIME_W-1:0]    req_now_ms,
   input  wire logic [dtq_pkg::DELAY_W-1:0]   req_delay_ms,
   input  wire logic [dtq_pkg::TAG_W-1:0]     req_tag,
   input  wire logic                          req_cancellable,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_kind,
   output logic [dtq_pkg::TAG_W-1:0]          rsp_fired_tag,
   output logic                               rsp_timer_set,
   output logic [dtq_pkg::TIME_W-1:0]         rsp_timer_at,
   output logic                               rsp_queue_full,
   output logic                               rsp_last
);

   localparam int TW = dtq_pkg::TIME_W;

   // sequencer state
   dtq_pkg::state_type state_ff, state_in;

   // latched request word
   logic [TW-1:0]                  now_ff;
   logic [dtq_pkg::DELAY_W-1:0]    delay_ff;
   logic [dtq_pkg::TAG_W-1:0]      tag_ff;
   logic                           canc_ff;

   // per-request working registers
   logic                           pulse_ff, pulse_in;
   logic                           full_ff, full_in;
   logic [TW-1:0]                  dl_ff, dl_in;
   logic [TW:0]                    limit_ff, limit_in;   // exact head + slack
   logic [TW-1:0]                  tnext_ff, tnext_in;   // saturated now + slack

   // persistent state
   logic [TW-1:0]                  armed_ff, armed_in;
   logic [dtq_pkg::SLACK_W-1:0]    slack_ff;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_kind_ff, rsp_kind_in;
   logic [dtq_pkg::TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic                           rsp_set_ff, rsp_set_in;
   logic [TW-1:0]                  rsp_at_ff, rsp_at_in;
   logic                           rsp_full_ff, rsp_full_in;
   logic                           rsp_last_ff, rsp_last_in;

   // cell chain
   dtq_pkg::cell_cmd_type          cmd;
   dtq_pkg::entry_type             slot [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]         slot_gt;
   logic [QUEUE_DEPTH-1:0]         slot_match;

   dtq_pkg::entry_type             head;
   logic                           out_free;
   logic                           req_take;
   logic [TW:0]                    dl_sum;
   logic [TW:0]                    tnext_sum;

   assign head      = slot[0];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == dtq_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_fired_tag  = rsp_tag_ff;
   assign rsp_timer_set  = rsp_set_ff;
   assign rsp_timer_at   = rsp_at_ff;
   assign rsp_queue_full = rsp_full_ff;
   assign rsp_last       = rsp_last_ff;

   // saturating sums, each feeding a register
   assign dl_sum    = {1'b0, now_ff} + {{(TW + 1 - dtq_pkg::DELAY_W){1'b0}}, delay_ff};
   assign tnext_sum = {1'b0, now_ff} + {{(TW + 1 - dtq_pkg::SLACK_W){1'b0}}, slack_ff};

   // cell row: each cell sees its left and right neighbor
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      dtq_pkg::entry_type left_e, right_e;
      logic               left_g, match_i;

      if (i == 0) begin : g_first
         assign left_e  = '0;
         assign left_g  = 1'b0;
         assign match_i = 1'b0;
      end else begin : g_mid
         assign left_e  = slot[i-1];
         assign left_g  = slot_gt[i-1];
         assign match_i = slot_match[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = slot[i+1];
      end

      dtq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_gt     (left_g),
         .right_entry (right_e),
         .match_in    (match_i),
         .entry       (slot[i]),
         .gt_out      (slot_gt[i]),
         .match_out   (slot_match[i])
      );
   end

   // sequencer: next state, chain command and output word
   always_comb begin
      logic keep;
      logic [TW-1:0] new_at;

      keep         = 1'b0;
      new_at       = armed_ff;
      state_in     = state_ff;
      pulse_in     = pulse_ff;
      full_in      = full_ff;
      dl_in        = dl_ff;
      limit_in     = limit_ff;
      tnext_in     = tnext_ff;
      armed_in     = armed_ff;

      cmd.op       = dtq_pkg::OP_HOLD;
      cmd.deadline = dl_ff;
      cmd.tag      = tag_ff;
      cmd.canc     = canc_ff;

      // output register drains when taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_set_in   = rsp_set_ff;
      rsp_at_in    = rsp_at_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         dtq_pkg::ST_IDLE: begin
            if (req_take) begin
               full_in  = 1'b0;
               pulse_in = (dtq_pkg::mode_type'(req_mode) == dtq_pkg::MODE_SCHEDULE)
                       || (dtq_pkg::mode_type'(req_mode) == dtq_pkg::MODE_TICK);
               unique case (dtq_pkg::mode_type'(req_mode))
                  dtq_pkg::MODE_SCHEDULE: state_in = dtq_pkg::ST_DEADLINE;
                  dtq_pkg::MODE_CANCEL:   state_in = dtq_pkg::ST_CANCEL;
                  dtq_pkg::MODE_TICK:     state_in = dtq_pkg::ST_FIRE;
                  default:                state_in = dtq_pkg::ST_STATUS;
               endcase
            end
         end
         dtq_pkg::ST_DEADLINE: begin
            // zero delay means deadline zero
            if (delay_ff == '0) begin
               dl_in = '0;
            end else if (dl_sum[TW]) begin
               dl_in = dtq_pkg::TIME_MAX;
            end else begin
               dl_in = dl_sum[TW-1:0];
            end
            state_in = dtq_pkg::ST_INSERT;
         end
         dtq_pkg::ST_INSERT: begin
            // last slot in use means the prefix covers the whole row
            if (slot[QUEUE_DEPTH-1].valid) begin
               full_in = 1'b1;
            end else begin
               cmd.op = dtq_pkg::OP_INSERT;
            end
            state_in = dtq_pkg::ST_FIRE;
         end
         dtq_pkg::ST_CANCEL: begin
            cmd.op   = dtq_pkg::OP_CANCEL;
            state_in = dtq_pkg::ST_STATUS;
         end
         dtq_pkg::ST_FIRE: begin
            if (head.valid && (head.deadline <= now_ff)) begin
               if (out_free) begin
                  cmd.op       = dtq_pkg::OP_POP;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = 1'b0;
                  rsp_tag_in   = head.tag;
                  rsp_set_in   = 1'b0;
                  rsp_at_in    = '0;
                  rsp_full_in  = 1'b0;
                  rsp_last_in  = 1'b0;
               end
            end else begin
               state_in = dtq_pkg::ST_CALC;
            end
         end
         dtq_pkg::ST_CALC: begin
            limit_in = {1'b0, head.deadline}
                     + {{(TW + 1 - dtq_pkg::SLACK_W){1'b0}}, slack_ff};
            tnext_in = tnext_sum[TW] ? dtq_pkg::TIME_MAX : tnext_sum[TW-1:0];
            state_in = dtq_pkg::ST_STATUS;
         end
         dtq_pkg::ST_STATUS: begin
            // leave the timer alone while it is still ahead and within slack
            keep = (now_ff < armed_ff) && ({1'b0, armed_ff} <= limit_ff);
            if (pulse_ff && head.valid && !keep) begin
               new_at = (tnext_ff > head.deadline) ? tnext_ff : head.deadline;
            end
            if (out_free) begin
               armed_in     = new_at;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = 1'b1;
               rsp_tag_in   = '0;
               rsp_set_in   = pulse_ff && head.valid && !keep;
               rsp_at_in    = new_at;
               rsp_full_in  = full_ff;
               rsp_last_in  = 1'b1;
               state_in     = dtq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtq_pkg::ST_IDLE;
         armed_ff     <= '0;
         slack_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pulse_ff     <= 1'b0;
         full_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
         pulse_ff     <= pulse_in;
         full_ff      <= full_in;
         if (csr_valid && csr_ready) begin
            slack_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         now_ff   <= req_now_ms;
         delay_ff <= req_delay_ms;
         tag_ff   <= req_tag;
         canc_ff  <= req_cancellable;
      end
      dl_ff       <= dl_in;
      limit_ff    <= limit_in;
      tnext_ff    <= tnext_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_set_ff  <= rsp_set_in;
      rsp_at_ff   <= rsp_at_in;
      rsp_full_ff <= rsp_full_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

`default_nettype wire
